// ===== rtl/mpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared sizes, status codes and the cell control bundle of the sorted
// max-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VALUE_W = 32;
  localparam int COUNT_OUT_W = 5;
  localparam int STATUS_W = 2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } mpq_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/mpq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: keeps its value, takes the inserted value or
// its left neighbor's value on a push, and its right neighbor's on a pop.
// ----------------------------------------------------------------------------
module mpq_cell (
  input  wire logic                               clk,
  input  wire mpq_pkg::mpq_ctrl_t                 ctrl,
  input  wire logic signed [mpq_pkg::VALUE_W-1:0] ins_value,
  input  wire logic                               occ,
  input  wire logic                               left_keep,
  input  wire logic signed [mpq_pkg::VALUE_W-1:0] left_value,
  input  wire logic signed [mpq_pkg::VALUE_W-1:0] right_value,
  output logic                                    keep,
  output logic signed [mpq_pkg::VALUE_W-1:0]      value,
  output logic signed [mpq_pkg::VALUE_W-1:0]      value_nxt
);

  logic signed [mpq_pkg::VALUE_W-1:0] value_r;

  assign keep = occ && (value_r > ins_value);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.push) begin
      if (!keep) begin
        value_nxt = left_keep ? ins_value : left_value;
      end
    end else if (ctrl.pop) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/max_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded max-priority queue of signed values held sorted in a cell chain.
// ----------------------------------------------------------------------------
// Each input beat is a push or a pop and yields one output beat carrying the
// largest stored value, the count, an empty flag and a status. Every cell
// compares against the pushed value in parallel and all cells shift together,
// so the block takes one beat per clock cycle whenever the output side accepts
// results; a beat's result is registered and appears in the cycle after it is
// taken, and the output register holds a stalled result while the input waits.
module max_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // value[31:0]
  input  wire logic [0:0]  in_tuser,  // func[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata  // top_value[31:0], count[36:32], empty_res[37],
                                      // status[39:38]
);

  localparam int N = mpq_pkg::CAPACITY;
  localparam int CW = mpq_pkg::CNT_W;
  localparam int VW = mpq_pkg::VALUE_W;

  logic [CW-1:0] count_r, count_nxt;
  logic out_valid_r;
  logic signed [VW-1:0] top_r;
  logic [mpq_pkg::COUNT_OUT_W-1:0] cnt_out_r;
  logic empty_r;
  logic [mpq_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic in_accept, full, empty, push_req, pop_req;
  mpq_pkg::mpq_ctrl_t ctrl;
  logic signed [VW-1:0] ins_value;

  logic [N-1:0] occ, keep;
  logic signed [VW-1:0] cell_value [N];
  logic signed [VW-1:0] cell_value_nxt [N];

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign ins_value = in_tdata;
  assign full = (count_r == CW'(N));
  assign empty = (count_r == '0);
  assign push_req = in_accept && (in_tuser[0] == mpq_pkg::FUNC_PUSH);
  assign pop_req = in_accept && (in_tuser[0] == mpq_pkg::FUNC_POP);
  assign ctrl.push = push_req && !full;
  assign ctrl.pop = pop_req && !empty;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic l_keep;
    logic signed [VW-1:0] l_val, r_val;

    assign occ[i] = (CW'(i) < count_r);
    if (i == 0) begin : g_head
      assign l_keep = 1'b1;
      assign l_val = ins_value;
    end else begin : g_body
      assign l_keep = keep[i-1];
      assign l_val = cell_value[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign r_val = cell_value[i];
    end else begin : g_inner
      assign r_val = cell_value[i+1];
    end

    mpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .ins_value  (ins_value),
      .occ        (occ[i]),
      .left_keep  (l_keep),
      .left_value (l_val),
      .right_value(r_val),
      .keep       (keep[i]),
      .value      (cell_value[i]),
      .value_nxt  (cell_value_nxt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    status_nxt = mpq_pkg::STATUS_OK;
    if (ctrl.push) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CW'(1);
    end else if (push_req) begin
      status_nxt = mpq_pkg::STATUS_FULL;
    end else if (pop_req) begin
      status_nxt = mpq_pkg::STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        count_r <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      top_r <= (count_nxt == '0) ? '0 : cell_value_nxt[0];
      cnt_out_r <= mpq_pkg::COUNT_OUT_W'(count_nxt);
      empty_r <= (count_nxt == '0);
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {status_r, empty_r, cnt_out_r, top_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N))
    else $error("queue count exceeds capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted push did not grow the queue");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && empty_r |-> top_r == '0)
    else $error("empty result carries a nonzero top value");

  a_pop_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    pop_req && empty |=> status_r == mpq_pkg::STATUS_EMPTY && empty_r)
    else $error("pop on empty queue not flagged");

endmodule
`default_nettype wire

// ===== verif/max_priority_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_queue_test
// Self-checking bench for the sorted max-priority queue.
// ----------------------------------------------------------------------------
// A short table of pushes and pops covers the empty, full, extreme and equal
// value cases. Random fill and drain phases follow. Every result beat is
// checked against a fixed table view or a sorted-array predictor, and both
// stream sides idle at random, with a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module max_priority_queue_test;
  import mpq_pkg::*;

  localparam int RANDOM_BEATS = 1726;
  localparam int LONG_HOLD = 64;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic                      empty_res;
    logic [COUNT_OUT_W-1:0]    count;
    logic signed [VALUE_W-1:0] top_value;
  } queue_view_t;

  typedef struct packed {
    logic               func;
    logic [VALUE_W-1:0] value;
    logic               fixed;
    queue_view_t        view;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  logic signed [VALUE_W-1:0] held_values [CAPACITY];
  int                        held_count;
  queue_view_t               awaited_views [$];
  int                        bad_beats;
  bit                        hold_off_req;

  table_row_t directed_rows [0:23] = '{
    '{FUNC_POP,  32'h0000_0000, 1'b1, '{STATUS_EMPTY, 1'b1, 5'd0, 32'sh0000_0000}},
    '{FUNC_PUSH, 32'h7FFF_FFFF, 1'b1, '{STATUS_OK, 1'b0, 5'd1, 32'sh7FFF_FFFF}},
    '{FUNC_PUSH, 32'h8000_0000, 1'b1, '{STATUS_OK, 1'b0, 5'd2, 32'sh7FFF_FFFF}},
    '{FUNC_POP,  32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 1'b0, 5'd1, 32'sh8000_0000}},
    '{FUNC_POP,  32'h0000_0000, 1'b1, '{STATUS_OK, 1'b1, 5'd0, 32'sh0000_0000}},
    '{FUNC_POP,  32'h1234_5678, 1'b1, '{STATUS_EMPTY, 1'b1, 5'd0, 32'sh0000_0000}},
    '{FUNC_PUSH, 32'h0000_0000, 1'b0, '0},
    '{FUNC_PUSH, 32'hFFFF_FFFF, 1'b0, '0},
    '{FUNC_PUSH, 32'h0000_0001, 1'b0, '0},
    '{FUNC_PUSH, 32'h0000_0005, 1'b0, '0},
    '{FUNC_PUSH, 32'h0000_0005, 1'b0, '0},
    '{FUNC_PUSH, 32'h8000_0000, 1'b0, '0},
    '{FUNC_PUSH, 32'h7FFF_FFFF, 1'b0, '0},
    '{FUNC_PUSH, 32'h7FFF_FFFE, 1'b0, '0},
    '{FUNC_PUSH, 32'h8000_0001, 1'b0, '0},
    '{FUNC_PUSH, 32'h0000_0005, 1'b0, '0},
    '{FUNC_PUSH, 32'hAAAA_AAAA, 1'b0, '0},
    '{FUNC_PUSH, 32'h5555_5555, 1'b0, '0},
    '{FUNC_PUSH, 32'hFFFF_0000, 1'b0, '0},
    '{FUNC_PUSH, 32'h0000_FFFF, 1'b0, '0},
    '{FUNC_PUSH, 32'h0000_0000, 1'b0, '0},
    '{FUNC_PUSH, 32'h7FFF_FFFF, 1'b0, '0},
    '{FUNC_PUSH, 32'h1234_5678, 1'b1, '{STATUS_FULL, 1'b0, 5'd16, 32'sh7FFF_FFFF}},
    '{FUNC_POP,  32'h0000_0000, 1'b0, '0}
  };

  max_priority_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one beat to the sorted array and returns the view it leaves.
  function automatic queue_view_t apply_queue_op(input logic func,
                                                 input logic signed [VALUE_W-1:0] value);
    queue_view_t view;
    int          pos;
    int          i;
    view.status = STATUS_OK;
    if (func == FUNC_PUSH) begin
      if (held_count >= CAPACITY) begin
        view.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_values[pos] > value) pos++;
        for (i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
        held_values[pos] = value;
        held_count++;
      end
    end else if (held_count == 0) begin
      view.status = STATUS_EMPTY;
    end else begin
      for (i = 0; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
      held_count--;
    end
    view.top_value = (held_count > 0) ? held_values[0] : '0;
    view.count = COUNT_OUT_W'(held_count);
    view.empty_res = (held_count == 0);
    return view;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2, 3: return VALUE_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input logic func, input logic [VALUE_W-1:0] value,
                           input logic fixed, input queue_view_t fixed_view, input int gap);
    queue_view_t predicted;
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
    predicted = apply_queue_op(func, value);
    awaited_views.push_back(fixed ? fixed_view : predicted);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int          phase_left;
    int          push_pct;
    bit          quiet;
    logic        func;
    int          n;
    int          gap;
    bad_beats = 0;
    held_count = 0;
    hold_off_req = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_beat(directed_rows[r].func, directed_rows[r].value, directed_rows[r].fixed,
                directed_rows[r].view, pick_gap());
    end

    phase_left = 0;
    push_pct = 50;
    quiet = 1'b0;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      if (n == 200 || n == 1400) hold_off_req = 1'b1;
      if (n == 900) begin
        in_tvalid <= 1'b0;
        while (awaited_views.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      func = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
      gap = quiet ? 0 : pick_gap();
      send_beat(func, pick_value(), 1'b0, '0, gap);
    end

    in_tvalid <= 1'b0;
    while (awaited_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_beats == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Output side: random stalls, steady stretches, and a long hold-off on request.
  initial begin
    int steady_left;
    int gap;
    steady_left = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (steady_left > 0) begin
        out_tready <= 1'b1;
        steady_left--;
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 49) == 0) steady_left = $urandom_range(30, 120);
          @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    queue_view_t got;
    queue_view_t want;
    got = out_tdata;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_views.size() == 0) begin
        if (bad_beats < MAX_REPORTS) begin
          $display("unexpected result beat: top=%0d count=%0d empty=%0b status=%0d",
                   got.top_value, got.count, got.empty_res, got.status);
        end
        bad_beats++;
      end else begin
        want = awaited_views.pop_front();
        if (got.top_value !== want.top_value || got.count !== want.count ||
            got.empty_res !== want.empty_res || got.status !== want.status) begin
          if (bad_beats < MAX_REPORTS) begin
            $display("mismatch at %0t: expected top=%0d count=%0d empty=%0b status=%0d",
                     $realtime, want.top_value, want.count, want.empty_res, want.status);
            $display("               actual   top=%0d count=%0d empty=%0b status=%0d",
                     got.top_value, got.count, got.empty_res, got.status);
          end
          bad_beats++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
